// File: rtl/core/sliding_trimmed_mean_filter_assert.svh
// assertion macros for the sliding trimmed mean filter
`ifndef SLIDING_TRIMMED_MEAN_FILTER_ASSERT_SVH
`define SLIDING_TRIMMED_MEAN_FILTER_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define STMF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);
// antecedent in one cycle implies consequent in the next
`define STMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define STMF_ASSERT_ALWAYS(label, prop, msg)
`define STMF_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/core/stmf_pkg.sv
// shared types for the sliding trimmed mean filter
package stmf_pkg;

  // what every cell of the sorted chain does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ROTATE
  } cell_op_e;

  // control passed from a cell to its right neighbor during insertion
  typedef struct packed {
    logic le;       // compacted entry of this cell is <= the new sample
    logic shifted;  // the oldest entry sits at or left of this cell
  } link_t;

endpackage

// File: rtl/core/stmf_cell.sv
// one cell of the sorted window chain: value plus age
module stmf_cell import stmf_pkg::*; #(
  parameter int SW         = 16,
  parameter int AW         = 3,
  parameter int WINDOW_LEN = 8,
  parameter int RESET_AGE  = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cell_op_e             op_i,
  input  logic signed [SW-1:0] sample_i,
  input  link_t                link_i,
  input  logic signed [SW-1:0] left_cmp_val_i,
  input  logic        [AW-1:0] left_cmp_age_i,
  input  logic signed [SW-1:0] left_val_i,
  input  logic        [AW-1:0] left_age_i,
  input  logic signed [SW-1:0] right_val_i,
  input  logic        [AW-1:0] right_age_i,
  input  logic                 right_valid_i,
  output logic signed [SW-1:0] val_o,
  output logic        [AW-1:0] age_o,
  output logic signed [SW-1:0] cmp_val_o,
  output logic        [AW-1:0] cmp_age_o,
  output link_t                link_o
);

  localparam logic [AW-1:0] OldAge = AW'(WINDOW_LEN - 1);

  logic signed [SW-1:0] val_q, val_d;
  logic        [AW-1:0] age_q, age_d;
  logic                 shifted;
  logic                 cmp_valid;
  logic                 le;

  // drop the oldest entry: cells at or right of it take the right neighbor
  assign shifted   = link_i.shifted | (age_q == OldAge);
  assign cmp_val_o = shifted ? right_val_i : val_q;
  assign cmp_age_o = shifted ? right_age_i : age_q;
  assign cmp_valid = shifted ? right_valid_i : 1'b1;
  assign le        = cmp_valid && (cmp_val_o <= sample_i);

  assign link_o.le      = le;
  assign link_o.shifted = shifted;

  always_comb begin
    val_d = val_q;
    age_d = age_q;
    unique case (op_i)
      OP_HOLD: begin
      end
      OP_INSERT: begin
        if (le) begin
          val_d = cmp_val_o;
          age_d = cmp_age_o + AW'(1);
        end else if (link_i.le) begin
          val_d = sample_i;
          age_d = '0;
        end else begin
          val_d = left_cmp_val_i;
          age_d = left_cmp_age_i + AW'(1);
        end
      end
      OP_ROTATE: begin
        val_d = left_val_i;
        age_d = left_age_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      age_q <= AW'(RESET_AGE);
    end else begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign val_o = val_q;
  assign age_o = age_q;

endmodule

// File: rtl/core/stmf_div.sv
// rounded division by a constant through a reciprocal multiply, half away from zero
module stmf_div #(
  parameter int SUM_W   = 19,
  parameter int OUT_W   = 16,
  parameter int DIVISOR = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] sum_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic signed [OUT_W-1:0] quot_o
);

  localparam int MAG_W  = SUM_W + 1;
  localparam int SHIFT  = MAG_W + $clog2(DIVISOR);
  localparam int RCP_W  = MAG_W + 1;
  localparam int PROD_W = MAG_W + RCP_W;
  // ceil(2^SHIFT / DIVISOR): exact floor quotient for every MAG_W-bit magnitude
  localparam logic [RCP_W-1:0] Recip =
    RCP_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [MAG_W-1:0]  sum_ext, mag;
  logic [MAG_W-1:0]  mag_q, mag_d;
  logic [PROD_W-1:0] prod;
  logic [OUT_W-1:0]  quo_q, quo_d;
  logic              neg_q, neg_d, busy_q, busy_d, done_q, done_d;

  // magnitude plus half the divisor, so the floor quotient rounds to nearest
  assign sum_ext = {sum_i[SUM_W-1], sum_i};
  assign mag     = (sum_ext[MAG_W-1] ? (~sum_ext + MAG_W'(1)) : sum_ext)
                   + MAG_W'(DIVISOR / 2);

  assign prod = PROD_W'(mag_q) * PROD_W'(Recip);

  // on start the magnitude is registered, then the quotient while busy
  always_comb begin
    mag_d  = mag_q;
    neg_d  = neg_q;
    quo_d  = quo_q;
    busy_d = 1'b0;
    done_d = done_q;
    if (start_i) begin
      mag_d  = mag;
      neg_d  = sum_i[SUM_W-1];
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      quo_d  = prod[SHIFT +: OUT_W];
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
    quo_q <= quo_d;
  end

  assign quot_o = neg_q ? (~quo_q + OUT_W'(1)) : quo_q;
  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// File: rtl/core/sliding_trimmed_mean_filter.sv
// top level of the sliding trimmed mean filter
// Sliding alpha-trimmed mean: every signed sample replaces the oldest of the last
// WINDOW_LEN samples (all zero after reset), the window is kept sorted, TRIM_COUNT/2
// values are dropped at each end (at most (WINDOW_LEN-1)/2) and the mean of the rest
// is returned, rounded to nearest with ties away from zero, one result per item.
// The window lives in a chain of cells that stays sorted: on the accept edge each cell
// drops the oldest entry and the new sample is inserted in place. The chain then
// rotates once around, feeding an accumulator, and the rounded division by the
// constant kept count, a reciprocal multiply, follows; the result then loads the
// output register, which holds the block back while it stays full. A new item is
// taken while the previous result still waits in the output register.
`include "sliding_trimmed_mean_filter_assert.svh"
module sliding_trimmed_mean_filter import stmf_pkg::*; #(
  parameter int WINDOW_LEN  = 8,
  parameter int TRIM_COUNT  = 2,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,   // sample
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_axis_tdata    // filtered_value
);

  localparam int DATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int SW       = SAMPLE_BITS;
  localparam int AW       = $clog2(WINDOW_LEN);
  localparam int KW       = $clog2(WINDOW_LEN);
  localparam int TRIM_RAW = TRIM_COUNT / 2;
  localparam int TRIM_MAX = (WINDOW_LEN - 1) / 2;
  localparam int TRIM     = (TRIM_RAW > TRIM_MAX) ? TRIM_MAX : TRIM_RAW;
  localparam int KEPT     = WINDOW_LEN - 2 * TRIM;
  localparam int SUM_W    = SW + $clog2(WINDOW_LEN);

  // control states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACC  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [KW-1:0]           k_q, k_d;
  logic signed [SUM_W-1:0] acc_q, acc_d, addend;
  logic                    in_accept, last_step, in_range, out_load;
  cell_op_e                op;
  logic signed [SW-1:0]    sample;

  logic signed [SW-1:0]    val   [WINDOW_LEN];
  logic        [AW-1:0]    age   [WINDOW_LEN];
  logic signed [SW-1:0]    cval  [WINDOW_LEN];
  logic        [AW-1:0]    cage  [WINDOW_LEN];
  link_t                   link  [WINDOW_LEN+1];
  logic [WINDOW_LEN-1:0]   old_vec;

  logic                    div_start, div_busy, div_done;
  logic signed [SW-1:0]    div_quot;

  logic                    m_valid_q, m_valid_d;
  logic signed [SW-1:0]    m_data_q;

  assign sample    = s_axis_tdata[SW-1:0];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // the sorted chain
  assign link[0] = '{le: 1'b1, shifted: 1'b0};

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    logic signed [SW-1:0] lcv, lv, rv;
    logic        [AW-1:0] lca, la, ra;
    logic                 rvalid;

    if (i == 0) begin : g_first
      assign lcv = '0;
      assign lca = '0;
      assign lv  = val[WINDOW_LEN-1];   // rotation wraps around
      assign la  = age[WINDOW_LEN-1];
    end else begin : g_inner
      assign lcv = cval[i-1];
      assign lca = cage[i-1];
      assign lv  = val[i-1];
      assign la  = age[i-1];
    end

    if (i == WINDOW_LEN - 1) begin : g_last
      assign rv     = '0;
      assign ra     = '0;
      assign rvalid = 1'b0;
    end else begin : g_notlast
      assign rv     = val[i+1];
      assign ra     = age[i+1];
      assign rvalid = 1'b1;
    end

    stmf_cell #(
      .SW         (SW),
      .AW         (AW),
      .WINDOW_LEN (WINDOW_LEN),
      .RESET_AGE  (i)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .op_i           (op),
      .sample_i       (sample),
      .link_i         (link[i]),
      .left_cmp_val_i (lcv),
      .left_cmp_age_i (lca),
      .left_val_i     (lv),
      .left_age_i     (la),
      .right_val_i    (rv),
      .right_age_i    (ra),
      .right_valid_i  (rvalid),
      .val_o          (val[i]),
      .age_o          (age[i]),
      .cmp_val_o      (cval[i]),
      .cmp_age_o      (cage[i]),
      .link_o         (link[i+1])
    );

    assign old_vec[i] = (age[i] == AW'(WINDOW_LEN - 1));
  end

  // after a full rotation the last cell has shown every sorted position once,
  // from the top down, so the kept range is symmetric in the step count
  assign last_step = (k_q == KW'(WINDOW_LEN - 1));
  assign in_range  = (k_q >= KW'(TRIM)) && (k_q <= KW'(WINDOW_LEN - 1 - TRIM));
  assign addend    = in_range ? {{(SUM_W - SW){val[WINDOW_LEN-1][SW-1]}},
                                 val[WINDOW_LEN-1]} : '0;

  assign div_start = (state_q == ST_ACC) && last_step;
  assign out_load  = (state_q == ST_DIV) && div_done && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    acc_d   = acc_q;
    op      = OP_HOLD;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          op      = OP_INSERT;
          k_d     = '0;
          acc_d   = '0;
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        op    = OP_ROTATE;
        acc_d = acc_q + addend;
        k_d   = k_q + KW'(1);
        if (last_step) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  stmf_div #(
    .SUM_W   (SUM_W),
    .OUT_W   (SW),
    .DIVISOR (KEPT)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (acc_d),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // output register
  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= div_quot;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = DATA_W'({{(DATA_W - SW){1'b0}}, m_data_q});

  // exactly one entry is the oldest, through insertion and rotation alike
  `STMF_ASSERT_ALWAYS(a_one_oldest, $countones(old_vec) == 1, "window ages lost uniqueness")
  // the divider only runs while the control waits for it
  `STMF_ASSERT_ALWAYS(a_div_owned, !div_busy || (state_q == ST_DIV), "divider busy out of turn")
  // an accepted item closes the input until its result is loaded
  `STMF_ASSERT_NEXT(a_accept_closes, in_accept, !s_axis_tready, "input reopened too early")
  // loads go only into a free or draining register; then the item shows and input reopens
  `STMF_ASSERT_NEXT(a_load_valid, out_load, m_axis_tvalid && s_axis_tready,
                    "result load did not present an item")

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the sliding trimmed mean filter
`timescale 1ns / 100ps

module tb_top;

  localparam int WIN = 8;
  localparam int TRIM = 2;
  localparam int SB = 16;
  localparam int TDW = ((SB + 7) / 8) * 8;
  localparam int N_RANDOM = 930;
  localparam int HOLD_AT = 300;    // accepted samples before the long output hold
  localparam int HOLD_LEN = 400;   // cycles of that hold
  localparam int DRAIN_CYCLES = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic           s_valid = 1'b0;
  logic           s_ready;
  logic [TDW-1:0] s_data = '0;
  logic           m_valid;
  logic           m_ready = 1'b0;
  logic [TDW-1:0] m_data;

  // samples waiting for the driver, filtered values waiting for the block
  logic [SB-1:0] sample_q [$];
  logic [SB-1:0] mean_q [$];

  // private copy of the window for prediction
  logic signed [SB-1:0] hist [WIN];
  int unsigned          hist_slot;

  int n_in;
  int n_out;
  int n_ties;
  int errors;
  int hold_left;
  bit hold_done;

  always #5 clk_i = ~clk_i;

  sliding_trimmed_mean_filter #(
    .WINDOW_LEN (WIN),
    .TRIM_COUNT (TRIM),
    .SAMPLE_BITS(SB)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data)
  );

  // write the sample over the oldest entry, sort a copy, drop the ends,
  // mean of the rest rounded to nearest with ties away from zero
  function automatic logic [SB-1:0] window_trimmed_mean(logic signed [SB-1:0] smp);
    logic signed [SB-1:0] srt [WIN];
    logic signed [SB-1:0] key;
    longint sum;
    longint mag;
    longint q;
    int trim;
    int cnt;
    int j;
    hist[hist_slot] = smp;
    hist_slot = (hist_slot + 1 == WIN) ? 0 : hist_slot + 1;
    srt = hist;
    for (int i = 1; i < WIN; i++) begin
      key = srt[i];
      j = i;
      while (j > 0 && srt[j-1] > key) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = key;
    end
    trim = TRIM / 2;
    if (trim > (WIN - 1) / 2) trim = (WIN - 1) / 2;
    cnt = WIN - 2 * trim;
    sum = 0;
    for (int i = trim; i < trim + cnt; i++) sum += srt[i];
    mag = (sum < 0) ? -sum : sum;
    if (2 * (mag % cnt) == cnt) n_ties++;
    q = (mag + cnt / 2) / cnt;
    return (sum < 0) ? SB'(-q) : SB'(q);
  endfunction

  // random sample: half full range, with small values for rounding ties,
  // the extremes and repeats mixed in
  function automatic logic [SB-1:0] pick_sample(logic [SB-1:0] prev);
    int mode;
    mode = $urandom_range(0, 9);
    case (mode)
      0, 1, 2, 3, 4: begin
        return SB'($urandom);
      end
      5, 6: begin
        return SB'(int'($urandom_range(0, 16)) - 8);
      end
      7: begin
        return $urandom_range(0, 1) ? {1'b0, {(SB-1){1'b1}}} : {1'b1, {(SB-1){1'b0}}};
      end
      8: begin
        return prev ^ SB'($urandom_range(0, 3));
      end
      default: begin
        return prev;
      end
    endcase
  endfunction

  // driver: bursts of random length separated by random gaps
  int burst_left;
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    logic           nv;
    logic [TDW-1:0] nd;
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data <= '0;
      burst_left = $urandom_range(1, 20);
      gap_left = 0;
    end else begin
      nv = s_valid;
      nd = s_data;
      if (!s_valid || s_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          nv = 1'b0;
        end else if (sample_q.size() > 0) begin
          nd = TDW'(sample_q.pop_front());
          nv = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            // a quarter of the bursts run straight into the next one
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          nv = 1'b0;
        end
      end
      s_valid <= nv;
      s_data <= nd;
    end
  end

  // long hold on the output side, once, while the driver keeps offering samples
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_in >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver: rotating stall pattern, reshuffled at random, a quarter of the time to no stalls
  logic [15:0] stall_pat;
  int          pat_cyc;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
      stall_pat = 16'hffff;
      pat_cyc = 0;
    end else begin
      pat_cyc++;
      if (pat_cyc % 64 == 0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
      end else begin
        stall_pat = {stall_pat[14:0], stall_pat[15]};
      end
      m_ready <= (hold_left == 0) && stall_pat[0];
    end
  end

  // monitor: results are checked before new samples are predicted
  always @(posedge clk_i) begin
    logic [SB-1:0] want;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        n_out <= n_out + 1;
        if (mean_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: unexpected output %h", $realtime, m_data);
        end else begin
          want = mean_q.pop_front();
          if (m_data !== TDW'(want)) begin
            errors++;
            if (errors <= 10)
              $display("%0t: filtered_value mismatch, expected %0d (%h) got %0d (%h)",
                       $realtime, $signed(want), want, $signed(m_data[SB-1:0]), m_data);
          end
        end
      end
      if (s_valid && s_ready) begin
        n_in <= n_in + 1;
        mean_q.push_back(window_trimmed_mean($signed(s_data[SB-1:0])));
      end
    end
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [SB-1:0] last;
    int            total;
    for (int i = 0; i < WIN; i++) hist[i] = '0;
    hist_slot = 0;
    n_in = 0;
    n_out = 0;
    n_ties = 0;
    errors = 0;

    // partly filled window, then a positive and a negative rounding tie
    sample_q = '{16'sd3, 16'sd3, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                 -16'sd3, -16'sd3};
    // WIN - 2 samples at each extreme, then one of each and a -1
    repeat (WIN - 2) sample_q.push_back(16'h7fff);
    repeat (WIN - 2) sample_q.push_back(16'h8000);
    sample_q.push_back(16'h7fff);
    sample_q.push_back(16'h8000);
    sample_q.push_back(16'hffff);

    last = '0;
    repeat (N_RANDOM) begin
      last = pick_sample(last);
      sample_q.push_back(last);
    end
    total = sample_q.size();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (n_in == total && mean_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d samples, checked %0d filtered values (%0d rounding ties)",
             n_in, n_out, n_ties);
    $display("output held off for %0d cycles once; %0d mismatches", HOLD_LEN, errors);
    if (errors == 0 && mean_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
